// ===== hw/rtl/qar_pkg.sv =====
`default_nettype none
package qar_pkg;

  localparam int TRIG_ITERATIONS = 24;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 31;
  localparam int AW              = 34;

  localparam logic signed [AW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [AW-1:0] PI_HALF_Q30 = 34'sd1686629713;
  localparam logic [63:0]          HALF_LSB    = 64'd536870912;

  typedef struct packed {
    logic [3:0][31:0]       p;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][31:0]       mag;
    logic signed [AW-1:0]   h;
    logic signed [AW-1:0]   cx;
    logic signed [AW-1:0]   cy;
    logic                   flip;
    logic [63:0]            n;
    logic [63:0]            res;
  } root_t;

  typedef struct packed {
    logic [3:0][31:0]       p;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][32:0]       rem;
    logic [2:0][30:0]       quo;
    logic [31:0]            nrm;
    logic signed [AW-1:0]   cx;
    logic signed [AW-1:0]   cy;
  } div_t;

  typedef struct packed {
    logic [3:0][31:0]       p;
    logic                   zero;
    logic [3:0][AW-1:0]     q;
  } rot_t;

  function automatic logic signed [AW-1:0] atan_q30(input int idx);
    case (idx)
      0:  atan_q30 = 34'sd843314857;
      1:  atan_q30 = 34'sd497837829;
      2:  atan_q30 = 34'sd263043837;
      3:  atan_q30 = 34'sd133525159;
      4:  atan_q30 = 34'sd67021687;
      5:  atan_q30 = 34'sd33543516;
      6:  atan_q30 = 34'sd16775851;
      7:  atan_q30 = 34'sd8388437;
      8:  atan_q30 = 34'sd4194283;
      9:  atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048576;
      11: atan_q30 = 34'sd524288;
      12: atan_q30 = 34'sd262144;
      13: atan_q30 = 34'sd131072;
      14: atan_q30 = 34'sd65536;
      15: atan_q30 = 34'sd32768;
      16: atan_q30 = 34'sd16384;
      17: atan_q30 = 34'sd8192;
      18: atan_q30 = 34'sd4096;
      19: atan_q30 = 34'sd2048;
      20: atan_q30 = 34'sd1024;
      21: atan_q30 = 34'sd512;
      22: atan_q30 = 34'sd256;
      23: atan_q30 = 34'sd128;
      24: atan_q30 = 34'sd64;
      25: atan_q30 = 34'sd32;
      26: atan_q30 = 34'sd16;
      27: atan_q30 = 34'sd8;
      28: atan_q30 = 34'sd4;
      29: atan_q30 = 34'sd2;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qar_front.sv =====
`default_nettype none
module qar_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [255:0]         in_data,
  output logic                 out_vld,
  output qar_pkg::root_t       out_data
);

  typedef struct packed {
    logic [3:0][31:0]               p;
    logic                           zero;
    logic [2:0]                     neg;
    logic [2:0][31:0]               mag;
    logic [4:0]                     sh;
    logic signed [qar_pkg::AW-1:0]  h;
    logic                           flip;
  } s1_t;

  typedef struct packed {
    logic [3:0][31:0]               p;
    logic                           zero;
    logic [2:0]                     neg;
    logic [2:0][31:0]               mag;
    logic [2:0][63:0]               sq;
    logic signed [qar_pkg::AW-1:0]  h;
    logic                           flip;
  } s2_t;

  s1_t             s1_nxt, s1_r;
  s2_t             s2_nxt, s2_r, s3_nxt, s3_r;
  qar_pkg::root_t  s4_nxt, s4_r;
  logic [3:0]      vld_r;

  // stage 1: magnitudes, scale count, half angle range reduction
  always_comb begin
    logic signed [31:0]             a;
    logic [31:0]                    m;
    logic signed [qar_pkg::AW-1:0]  h2;
    s1_nxt = '0;
    for (int i = 0; i < 4; i++) s1_nxt.p[i] = in_data[32*i +: 32];
    for (int l = 0; l < 3; l++) begin
      a = in_data[128 + 32*l +: 32];
      s1_nxt.neg[l] = a[31];
      s1_nxt.mag[l] = a[31] ? -a : a;
    end
    m = s1_nxt.mag[0];
    if (s1_nxt.mag[1] > m) m = s1_nxt.mag[1];
    if (s1_nxt.mag[2] > m) m = s1_nxt.mag[2];
    for (int i = 0; i < 30; i++) begin
      if (m[i]) s1_nxt.sh = 5'(30 - i);
    end
    if (m[31] || m[30]) s1_nxt.sh = '0;
    s1_nxt.zero = (m == '0);
    h2 = {in_data[255], in_data[255:224], 1'b0};
    if (h2 > qar_pkg::PI_HALF_Q30) begin
      s1_nxt.h    = h2 - qar_pkg::PI_Q30;
      s1_nxt.flip = 1'b1;
    end else if (h2 < -qar_pkg::PI_HALF_Q30) begin
      s1_nxt.h    = h2 + qar_pkg::PI_Q30;
      s1_nxt.flip = 1'b1;
    end else begin
      s1_nxt.h    = h2;
      s1_nxt.flip = 1'b0;
    end
  end

  // stage 2: scale axis up
  always_comb begin
    s2_nxt      = '0;
    s2_nxt.p    = s1_r.p;
    s2_nxt.zero = s1_r.zero;
    s2_nxt.neg  = s1_r.neg;
    s2_nxt.h    = s1_r.h;
    s2_nxt.flip = s1_r.flip;
    for (int l = 0; l < 3; l++) s2_nxt.mag[l] = s1_r.mag[l] << s1_r.sh;
  end

  // stage 3: squares
  always_comb begin
    s3_nxt = s2_r;
    for (int l = 0; l < 3; l++) s3_nxt.sq[l] = s2_r.mag[l] * s2_r.mag[l];
  end

  // stage 4: sum of squares, CORDIC seed
  always_comb begin
    s4_nxt      = '0;
    s4_nxt.p    = s3_r.p;
    s4_nxt.zero = s3_r.zero;
    s4_nxt.neg  = s3_r.neg;
    s4_nxt.mag  = s3_r.mag;
    s4_nxt.h    = s3_r.h;
    s4_nxt.flip = s3_r.flip;
    s4_nxt.cx   = qar_pkg::GAIN_Q30;
    s4_nxt.cy   = '0;
    s4_nxt.n    = s3_r.sq[0] + s3_r.sq[1] + s3_r.sq[2];
    s4_nxt.res  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_data = s4_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qar_root_trig.sv =====
`default_nettype none
module qar_root_trig (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  qar_pkg::root_t   in_data,
  output logic             out_vld,
  output qar_pkg::root_t   out_data
);

  qar_pkg::root_t                     st_r [qar_pkg::SQRT_STEPS];
  logic [qar_pkg::SQRT_STEPS-1:0]     vld_r;

  for (genvar k = 0; k < qar_pkg::SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    qar_pkg::root_t cur, nxt;
    logic           vin;

    if (k == 0) begin : g_first
      assign cur = in_data;
      assign vin = in_vld;
    end else begin : g_next
      assign cur = st_r[k-1];
      assign vin = vld_r[k-1];
    end

    always_comb begin
      logic [63:0]                    trial;
      logic signed [qar_pkg::AW-1:0]  dx, dy;
      nxt   = cur;
      trial = cur.res + BIT;
      if (cur.n >= trial) begin
        nxt.n   = cur.n - trial;
        nxt.res = (cur.res >> 1) + BIT;
      end else begin
        nxt.res = cur.res >> 1;
      end
      dx = cur.cy >>> k;
      dy = cur.cx >>> k;
      if (k < qar_pkg::TRIG_ITERATIONS) begin
        if (!cur.h[qar_pkg::AW-1]) begin
          nxt.cx = cur.cx - dx;
          nxt.cy = cur.cy + dy;
          nxt.h  = cur.h - qar_pkg::atan_q30(k);
        end else begin
          nxt.cx = cur.cx + dx;
          nxt.cy = cur.cy - dy;
          nxt.h  = cur.h + qar_pkg::atan_q30(k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign out_vld  = vld_r[qar_pkg::SQRT_STEPS-1];
  assign out_data = st_r[qar_pkg::SQRT_STEPS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/qar_divide.sv =====
`default_nettype none
module qar_divide (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  qar_pkg::root_t   in_data,
  output logic             out_vld,
  output qar_pkg::rot_t    out_data
);

  qar_pkg::div_t                     st_r [qar_pkg::DIV_STEPS];
  logic [qar_pkg::DIV_STEPS-1:0]     vld_r;
  qar_pkg::div_t                     d0;

  logic [3:0][31:0]                  v1_p_r;
  logic                              v1_zero_r;
  logic signed [qar_pkg::AW-1:0]     v1_cx_r;
  logic [2:0][63:0]                  v1_prod_r, v1_prod_nxt;
  logic                              v1_vld_r;
  qar_pkg::rot_t                     v2_r, v2_nxt;
  logic                              v2_vld_r;

  always_comb begin
    d0      = '0;
    d0.p    = in_data.p;
    d0.zero = in_data.zero;
    d0.neg  = in_data.neg;
    d0.nrm  = in_data.res[31:0];
    d0.cx   = in_data.flip ? -in_data.cx : in_data.cx;
    d0.cy   = in_data.flip ? -in_data.cy : in_data.cy;
    for (int l = 0; l < 3; l++) d0.rem[l] = {1'b0, in_data.mag[l]};
  end

  // restoring divide, one quotient bit per stage, three lanes
  for (genvar j = 0; j < qar_pkg::DIV_STEPS; j++) begin : g_step
    localparam int QB = qar_pkg::DIV_STEPS - 1 - j;
    qar_pkg::div_t cur, nxt;
    logic          vin;

    if (j == 0) begin : g_first
      assign cur = d0;
      assign vin = in_vld;
    end else begin : g_next
      assign cur = st_r[j-1];
      assign vin = vld_r[j-1];
    end

    always_comb begin
      logic [32:0] rv;
      nxt = cur;
      for (int l = 0; l < 3; l++) begin
        rv = (j == 0) ? cur.rem[l] : {cur.rem[l][31:0], 1'b0};
        if (rv >= {1'b0, cur.nrm}) begin
          nxt.rem[l]     = rv - {1'b0, cur.nrm};
          nxt.quo[l][QB] = 1'b1;
        end else begin
          nxt.rem[l] = rv;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= nxt;
      end
    end
  end

  // unit axis times sine
  always_comb begin
    logic signed [63:0] ue, cye;
    qar_pkg::div_t      dl;
    dl  = st_r[qar_pkg::DIV_STEPS-1];
    cye = {{(64-qar_pkg::AW){dl.cy[qar_pkg::AW-1]}}, dl.cy};
    for (int l = 0; l < 3; l++) begin
      ue = {33'd0, dl.quo[l]};
      if (dl.neg[l]) ue = -ue;
      v1_prod_nxt[l] = ue * cye;
    end
  end

  always_comb begin
    logic signed [63:0] rs;
    v2_nxt      = '0;
    v2_nxt.p    = v1_p_r;
    v2_nxt.zero = v1_zero_r;
    v2_nxt.q[0] = v1_cx_r;
    for (int l = 0; l < 3; l++) begin
      rs = $signed(v1_prod_r[l] + qar_pkg::HALF_LSB) >>> 30;
      v2_nxt.q[l+1] = rs[qar_pkg::AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_vld_r <= 1'b0;
      v2_vld_r <= 1'b0;
    end else if (en) begin
      v1_vld_r <= vld_r[qar_pkg::DIV_STEPS-1];
      v2_vld_r <= v1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_p_r    <= st_r[qar_pkg::DIV_STEPS-1].p;
      v1_zero_r <= st_r[qar_pkg::DIV_STEPS-1].zero;
      v1_cx_r   <= st_r[qar_pkg::DIV_STEPS-1].cx;
      v1_prod_r <= v1_prod_nxt;
      v2_r      <= v2_nxt;
    end
  end

  assign out_vld  = v2_vld_r;
  assign out_data = v2_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qar_rotate.sv =====
`default_nettype none
module qar_rotate (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  qar_pkg::rot_t    in_data,
  output logic             out_vld,
  output logic [3:0][31:0] out_q,
  output logic             out_zero
);

  // products m[i][j] = a_i * b_j, summed into Hamilton order, rounded by 2^-30
  function automatic logic [3:0][qar_pkg::AW-1:0] hsum(input logic [3:0][3:0][63:0] m);
    logic [3:0][63:0]   s;
    logic signed [63:0] v;
    s[0] = m[0][0] - m[1][1] - m[2][2] - m[3][3];
    s[1] = m[0][1] + m[1][0] + m[2][3] - m[3][2];
    s[2] = m[0][2] - m[1][3] + m[2][0] + m[3][1];
    s[3] = m[0][3] + m[1][2] - m[2][1] + m[3][0];
    for (int i = 0; i < 4; i++) begin
      v = $signed(s[i] + qar_pkg::HALF_LSB) >>> 30;
      hsum[i] = v[qar_pkg::AW-1:0];
    end
  endfunction

  logic [3:0][3:0][63:0]           pr1_r, pr1_nxt, pr2_r, pr2_nxt;
  logic [3:0][qar_pkg::AW-1:0]     q1_r, q2_r, t_r;
  logic [3:0][31:0]                p1_r, p2_r, p3_r, q_nxt;
  logic [2:0]                      zero_r;
  logic [3:0]                      vld_r;
  logic [3:0][31:0]                out_q_r;
  logic                            out_zero_r;

  always_comb begin
    logic signed [63:0] ae, be;
    for (int i = 0; i < 4; i++) begin
      ae = {{(64-qar_pkg::AW){in_data.q[i][qar_pkg::AW-1]}}, in_data.q[i]};
      for (int j = 0; j < 4; j++) begin
        be = {{32{in_data.p[j][31]}}, in_data.p[j]};
        pr1_nxt[i][j] = ae * be;
      end
    end
  end

  always_comb begin
    logic signed [63:0] ae, be;
    for (int i = 0; i < 4; i++) begin
      ae = {{(64-qar_pkg::AW){t_r[i][qar_pkg::AW-1]}}, t_r[i]};
      for (int j = 0; j < 4; j++) begin
        be = {{(64-qar_pkg::AW){q2_r[j][qar_pkg::AW-1]}}, q2_r[j]};
        if (j != 0) be = -be;
        pr2_nxt[i][j] = ae * be;
      end
    end
  end

  always_comb begin
    logic [3:0][qar_pkg::AW-1:0]   r;
    logic signed [qar_pkg::AW-1:0] rs;
    r = hsum(pr2_r);
    for (int i = 0; i < 4; i++) begin
      rs = r[i];
      if (rs > 34'sd2147483647) q_nxt[i] = 32'h7FFF_FFFF;
      else if (rs < -34'sd2147483648) q_nxt[i] = 32'h8000_0000;
      else q_nxt[i] = rs[31:0];
      if (zero_r[2]) q_nxt[i] = p3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1_r      <= pr1_nxt;
      q1_r       <= in_data.q;
      p1_r       <= in_data.p;
      t_r        <= hsum(pr1_r);
      q2_r       <= q1_r;
      p2_r       <= p1_r;
      pr2_r      <= pr2_nxt;
      p3_r       <= p2_r;
      zero_r     <= {zero_r[1:0], in_data.zero};
      out_q_r    <= q_nxt;
      out_zero_r <= zero_r[2];
    end
  end

  assign out_vld  = vld_r[3];
  assign out_q    = out_q_r;
  assign out_zero = out_zero_r;

endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_axis_angle_rotate_core.sv =====
// Rotates quaternion p by angle turn_angle (Q4.28 rad) about axis (Q16.16, any length):
// out = q*p*conj(q), q = (cos(a/2), u*sin(a/2)), each component saturated to 32 bits.
// A zero axis sets out_tuser and returns p unchanged. One word is accepted per clock
// while the pipeline is not held. Data passes the 32-stage square root and then the
// 31-stage divider (the 24-step CORDIC runs alongside the root). The pipeline holds in
// place while out_tready is low and the output register is full.
`default_nettype none
module quaternion_axis_angle_rotate_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_w, in_x, in_y, in_z, axis_x, axis_y, axis_z, turn_angle (32 bits each)
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_w, out_x, out_y, out_z (32 bits each)
  output logic [127:0] out_tdata,
  // axis_zero
  output logic         out_tuser
);

  logic             en;
  logic             f_vld, r_vld, d_vld, o_vld;
  qar_pkg::root_t   f_data, r_data;
  qar_pkg::rot_t    d_data;
  logic [3:0][31:0] o_q;
  logic             o_zero;

  assign en        = !o_vld || out_tready;
  assign in_tready = en;

  qar_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid && in_tready), .in_data(in_tdata),
    .out_vld(f_vld), .out_data(f_data)
  );

  qar_root_trig u_root (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(f_vld), .in_data(f_data),
    .out_vld(r_vld), .out_data(r_data)
  );

  qar_divide u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(r_vld), .in_data(r_data),
    .out_vld(d_vld), .out_data(d_data)
  );

  qar_rotate u_rot (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(d_vld), .in_data(d_data),
    .out_vld(o_vld), .out_q(o_q), .out_zero(o_zero)
  );

  assign out_tvalid = o_vld;
  assign out_tdata  = o_q;
  assign out_tuser  = o_zero;

endmodule
`default_nettype wire

// ===== hw/rtl/qar_check.sv =====
`default_nettype none
module qar_check (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("out word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline held");

endmodule

bind quaternion_axis_angle_rotate_core qar_check u_qar_check (
  .clk(clk), .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire
